FILE: rtl/core/cbs_pkg.sv
// Package for the cubic Bezier split unit: widths, pipeline stage indices,
// lane codes and the item, weight and control types.
// Used by every module in rtl/core; depends on nothing.
package cbs_pkg;

  localparam int CoordW    = 32;
  localparam int TFracBits = 16;
  localparam int TW        = TFracBits + 1;

  // Weight widths by degree: a degree-n weight is at most 2^(n*TFracBits).
  localparam int W1  = TFracBits + 1;
  localparam int W2  = 2 * TFracBits + 1;
  localparam int W3  = 3 * TFracBits + 1;
  localparam int WtW = W3;

  // Lane weights are split into two limbs so each product stays near 32x32.
  localparam int LoBits  = (WtW + 1) / 2;
  localparam int HiBits  = WtW - LoBits;
  localparam int ProdLoW = CoordW + LoBits + 1;
  localparam int ProdHiW = CoordW + HiBits + 1;
  localparam int PointW  = CoordW + WtW + 1;
  localparam int AccW    = PointW + 2;
  localparam int RndShift = 3 * TFracBits;

  localparam int NumAxes  = 2;
  localparam int NumKinds = 5;
  localparam int NumLanes = NumAxes * NumKinds;
  localparam int NumPts   = 4;

  // Lane kinds, in output order.
  localparam int KindLc1   = 0;
  localparam int KindLc2   = 1;
  localparam int KindSplit = 2;
  localparam int KindRc1   = 3;
  localparam int KindRc2   = 4;

  // Pipeline stage indices.
  localparam int StW1      = 0;
  localparam int StW2      = 1;
  localparam int StMul     = 2;
  localparam int StComb    = 3;
  localparam int StPair    = 4;
  localparam int StSum     = 5;
  localparam int StOut     = 6;
  localparam int NumStages = 7;

  localparam logic [TW-1:0] TOne = TW'(1) << TFracBits;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [NumPts-1:0][CoordW-1:0] coord_quad_t;
  typedef logic [NumPts-1:0][WtW-1:0] wt_quad_t;
  typedef logic [NumLanes-1:0][AccW-1:0] acc_all_t;

  typedef struct packed {
    coord_t          start_x;
    coord_t          start_y;
    coord_t          first_ctrl_x;
    coord_t          first_ctrl_y;
    coord_t          second_ctrl_x;
    coord_t          second_ctrl_y;
    coord_t          end_x;
    coord_t          end_y;
    logic [TW-1:0]   split_t;
  } cbs_in_t;

  typedef struct packed {
    coord_t left_c1_x;
    coord_t left_c1_y;
    coord_t left_c2_x;
    coord_t left_c2_y;
    coord_t split_x;
    coord_t split_y;
    coord_t right_c1_x;
    coord_t right_c1_y;
    coord_t right_c2_x;
    coord_t right_c2_y;
  } cbs_out_t;

  typedef struct packed {
    logic [1:0][W1-1:0] d1;
    logic [2:0][W2-1:0] d2;
    logic [3:0][W3-1:0] d3;
  } cbs_wts_t;

  // Per-stage advance strobes.
  typedef struct packed {
    logic w1;
    logic w2;
    logic mul;
    logic comb;
    logic pair;
    logic sum;
    logic out;
  } cbs_adv_t;

endpackage

FILE: rtl/core/cbs_weights.sv
// Bernstein weight generator: clamps t, forms s = 1 - t and the degree
// one, two and three weights over two registered stages. Uses cbs_pkg.
module cbs_weights (
  input  logic                        clk_i,
  input  cbs_pkg::cbs_adv_t           adv_i,
  input  logic [cbs_pkg::TW-1:0]      split_t_i,
  output cbs_pkg::cbs_wts_t           wts_o
);
  import cbs_pkg::*;

  logic [TW-1:0]      t_c, s_c;
  logic [W1+1:0]      t3x_d;
  logic [2*W1-1:0]    s2_p, st_p, t2_p;
  logic [W1-1:0]      s_q, t_q;
  logic [W1+1:0]      t3x_q;
  logic [W2-1:0]      s2_q, st_q, t2_q;
  logic [W2+W1-1:0]   s3_p, t3_p;
  logic [W2+W1+1:0]   s2t_p, st2_p;
  cbs_wts_t           wts_q;

  always_comb begin
    t_c   = (split_t_i > TOne) ? TOne : split_t_i;
    s_c   = TOne - t_c;
    t3x_d = (W1 + 2)'({t_c, 1'b0}) + (W1 + 2)'(t_c);
    s2_p  = (2 * W1)'(s_c) * (2 * W1)'(s_c);
    st_p  = (2 * W1)'(s_c) * (2 * W1)'(t_c);
    t2_p  = (2 * W1)'(t_c) * (2 * W1)'(t_c);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.w1) begin
      s_q   <= s_c;
      t_q   <= t_c;
      t3x_q <= t3x_d;
      s2_q  <= s2_p[W2-1:0];
      st_q  <= st_p[W2-1:0];
      t2_q  <= t2_p[W2-1:0];
    end
  end

  // The factor three of the cubic middle weights rides on 3t.
  always_comb begin
    s3_p  = (W2 + W1)'(s2_q) * (W2 + W1)'(s_q);
    t3_p  = (W2 + W1)'(t2_q) * (W2 + W1)'(t_q);
    s2t_p = (W2 + W1 + 2)'(s2_q) * (W2 + W1 + 2)'(t3x_q);
    st2_p = (W2 + W1 + 2)'(st_q) * (W2 + W1 + 2)'(t3x_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.w2) begin
      wts_q.d1[0] <= s_q;
      wts_q.d1[1] <= t_q;
      wts_q.d2[0] <= s2_q;
      wts_q.d2[1] <= {st_q[W2-2:0], 1'b0};
      wts_q.d2[2] <= t2_q;
      wts_q.d3[0] <= s3_p[W3-1:0];
      wts_q.d3[1] <= s2t_p[W3-1:0];
      wts_q.d3[2] <= st2_p[W3-1:0];
      wts_q.d3[3] <= t3_p[W3-1:0];
    end
  end

  assign wts_o = wts_q;

endmodule

FILE: rtl/core/cbs_lane.sv
// One lane: exact weighted sum of four coordinates with four weights,
// limb products, per-point combine, pair sums and final sum. Uses cbs_pkg.
module cbs_lane (
  input  logic                              clk_i,
  input  cbs_pkg::cbs_adv_t                 adv_i,
  input  cbs_pkg::coord_quad_t              pts_i,
  input  cbs_pkg::wt_quad_t                 wts_i,
  output logic signed [cbs_pkg::AccW-1:0]   acc_o
);
  import cbs_pkg::*;

  logic signed [ProdLoW-1:0] plo_d [NumPts];
  logic signed [ProdHiW-1:0] phi_d [NumPts];
  logic signed [ProdLoW-1:0] plo_q [NumPts];
  logic signed [ProdHiW-1:0] phi_q [NumPts];
  logic signed [PointW-1:0]  pp_d  [NumPts];
  logic signed [PointW-1:0]  pp_q  [NumPts];
  logic signed [AccW-1:0]    pr_q  [2];
  logic signed [AccW-1:0]    acc_q;

  // Weights are unsigned, so each limb gets a zero sign bit.
  always_comb begin
    for (int i = 0; i < NumPts; i++) begin
      plo_d[i] = $signed(pts_i[i]) * $signed({1'b0, wts_i[i][LoBits-1:0]});
      phi_d[i] = $signed(pts_i[i]) * $signed({1'b0, wts_i[i][WtW-1:LoBits]});
      pp_d[i]  = PointW'(plo_q[i]) + (PointW'(phi_q[i]) <<< LoBits);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.mul) begin
      for (int i = 0; i < NumPts; i++) begin
        plo_q[i] <= plo_d[i];
        phi_q[i] <= phi_d[i];
      end
    end
    if (adv_i.comb) begin
      for (int i = 0; i < NumPts; i++) begin
        pp_q[i] <= pp_d[i];
      end
    end
    if (adv_i.pair) begin
      pr_q[0] <= AccW'(pp_q[0]) + AccW'(pp_q[1]);
      pr_q[1] <= AccW'(pp_q[2]) + AccW'(pp_q[3]);
    end
    if (adv_i.sum) begin
      acc_q <= pr_q[0] + pr_q[1];
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/core/cbs_merge.sv
// Merge stage: rounds every lane sum half away from zero, drops the weight
// scale and packs the result item into the output register. Uses cbs_pkg.
module cbs_merge (
  input  logic                 clk_i,
  input  cbs_pkg::cbs_adv_t    adv_i,
  input  cbs_pkg::acc_all_t    acc_i,
  output cbs_pkg::cbs_out_t    out_o
);
  import cbs_pkg::*;

  localparam logic [AccW-1:0] Half = AccW'(1) << (RndShift - 1);

  logic [AccW-1:0]   biased [NumLanes];
  coord_t            rnd    [NumLanes];
  cbs_out_t          out_d;
  cbs_out_t          out_q;

  // A negative sum takes one less bias, which turns the floor of the
  // arithmetic shift into rounding away from zero on ties.
  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      biased[k] = acc_i[k] + Half - AccW'(acc_i[k][AccW-1]);
      rnd[k]    = biased[k][RndShift +: CoordW];
    end
    out_d.left_c1_x  = rnd[KindLc1 * NumAxes];
    out_d.left_c1_y  = rnd[KindLc1 * NumAxes + 1];
    out_d.left_c2_x  = rnd[KindLc2 * NumAxes];
    out_d.left_c2_y  = rnd[KindLc2 * NumAxes + 1];
    out_d.split_x    = rnd[KindSplit * NumAxes];
    out_d.split_y    = rnd[KindSplit * NumAxes + 1];
    out_d.right_c1_x = rnd[KindRc1 * NumAxes];
    out_d.right_c1_y = rnd[KindRc1 * NumAxes + 1];
    out_d.right_c2_x = rnd[KindRc2 * NumAxes];
    out_d.right_c2_y = rnd[KindRc2 * NumAxes + 1];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.out) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

FILE: rtl/core/cubic_bezier_split_at_t_unit.sv
// Cubic Bezier split at t. Takes one item per cycle while in_stall_o is low and
// returns one result item per item. The rate is one item per clock when the
// output is not stalled; the latency is set by the weight stages, the limb
// multipliers of the ten lanes (one per output coordinate) and their adder
// tree. Empty stages fill while a finished result waits, so up to seven items
// can be in flight. Depends on cbs_pkg, cbs_weights, cbs_lane and cbs_merge.
module cubic_bezier_split_at_t_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cbs_pkg::cbs_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cbs_pkg::cbs_out_t out_item_o
);
  import cbs_pkg::*;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv_v;
  cbs_adv_t             adv;
  coord_quad_t          pts_d  [NumAxes];
  coord_quad_t          pts1_q [NumAxes];
  coord_quad_t          pts2_q [NumAxes];
  cbs_wts_t             wts;
  wt_quad_t             lane_w [NumKinds];
  acc_all_t             acc;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv_v[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv_v[k] = !vld_q[k] || adv_v[k+1];
    end
    adv.w1   = adv_v[StW1];
    adv.w2   = adv_v[StW2];
    adv.mul  = adv_v[StMul];
    adv.comb = adv_v[StComb];
    adv.pair = adv_v[StPair];
    adv.sum  = adv_v[StSum];
    adv.out  = adv_v[StOut];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv_v[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv_v[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !adv_v[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_comb begin
    pts_d[0] = {in_item_i.end_x, in_item_i.second_ctrl_x,
                in_item_i.first_ctrl_x, in_item_i.start_x};
    pts_d[1] = {in_item_i.end_y, in_item_i.second_ctrl_y,
                in_item_i.first_ctrl_y, in_item_i.start_y};
  end

  // The points follow the weights through the two weight stages.
  always_ff @(posedge clk_i) begin
    if (adv.w1) begin
      pts1_q <= pts_d;
    end
    if (adv.w2) begin
      pts2_q <= pts1_q;
    end
  end

  cbs_weights u_weights (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .split_t_i (in_item_i.split_t),
    .wts_o     (wts)
  );

  // Every lane sums over all four points at the cubic scale; lower-degree
  // weights are shifted up so one rounding shift serves all lanes.
  always_comb begin
    for (int k = 0; k < NumKinds; k++) begin
      lane_w[k] = '0;
    end
    lane_w[KindLc1][0] = WtW'(wts.d1[0]) << (2 * TFracBits);
    lane_w[KindLc1][1] = WtW'(wts.d1[1]) << (2 * TFracBits);
    for (int i = 0; i < 3; i++) begin
      lane_w[KindLc2][i]   = WtW'(wts.d2[i]) << TFracBits;
      lane_w[KindRc1][i+1] = WtW'(wts.d2[i]) << TFracBits;
    end
    for (int i = 0; i < NumPts; i++) begin
      lane_w[KindSplit][i] = wts.d3[i];
    end
    lane_w[KindRc2][2] = WtW'(wts.d1[0]) << (2 * TFracBits);
    lane_w[KindRc2][3] = WtW'(wts.d1[1]) << (2 * TFracBits);
  end

  for (genvar kd = 0; kd < NumKinds; kd++) begin : g_kind
    for (genvar ax = 0; ax < NumAxes; ax++) begin : g_axis
      cbs_lane u_lane (
        .clk_i (clk_i),
        .adv_i (adv),
        .pts_i (pts2_q[ax]),
        .wts_i (lane_w[kd]),
        .acc_o (acc[kd * NumAxes + ax])
      );
    end
  end

  cbs_merge u_merge (
    .clk_i (clk_i),
    .adv_i (adv),
    .acc_i (acc),
    .out_o (out_item_o)
  );

endmodule

FILE: test/tb_cubic_bezier_split_at_t_unit.sv
// Self-checking testbench for cubic_bezier_split_at_t_unit: random and directed curves
// with split parameters, checked against an exact wide-integer Bernstein predictor.
// Depends on cbs_pkg and the unit itself; reads no files.
module tb_cubic_bezier_split_at_t_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cbs_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 300;

  typedef logic [TW-1:0] tval_t;

  // Holds the expected split results in acceptance order and checks arrivals.
  class split_scoreboard;
    cbs_out_t expected_q[$];
    int n_accepted;
    int n_checked;
    int n_errors;

    // Exact Bernstein sum of degree deg over the first deg+1 points, rounded
    // to nearest with halves away from zero.
    function coord_t blend(coord_t p0, coord_t p1, coord_t p2, coord_t p3,
                           int deg, tval_t t);
      logic signed [127:0] acc;
      logic signed [127:0] wt;
      logic signed [127:0] pv;
      logic signed [127:0] sv;
      logic signed [127:0] tv;
      logic [127:0]        mag;
      coord_t              pts[4];
      logic                neg;
      int                  i;
      int                  j;
      int                  sh;
      pts[0] = p0;
      pts[1] = p1;
      pts[2] = p2;
      pts[3] = p3;
      tv = 128'(t);
      sv = 128'(TOne) - tv;
      acc = '0;
      for (i = 0; i <= deg; i++) begin
        if (i == 0 || i == deg) begin
          wt = 128'sd1;
        end else begin
          wt = 128'(deg);
        end
        for (j = 0; j < deg - i; j++) wt = wt * sv;
        for (j = 0; j < i; j++) wt = wt * tv;
        pv = $signed(pts[i]);
        acc = acc + pv * wt;
      end
      sh = deg * TFracBits;
      neg = acc[127];
      mag = neg ? -acc : acc;
      mag = (mag + (128'd1 << (sh - 1))) >> sh;
      if (neg) mag = -mag;
      return mag[CoordW-1:0];
    endfunction

    function void note_input(cbs_in_t it);
      cbs_out_t exp_item;
      tval_t    t;
      t = (it.split_t > TOne) ? TOne : it.split_t;
      exp_item.left_c1_x  = blend(it.start_x, it.first_ctrl_x, '0, '0, 1, t);
      exp_item.left_c1_y  = blend(it.start_y, it.first_ctrl_y, '0, '0, 1, t);
      exp_item.left_c2_x  = blend(it.start_x, it.first_ctrl_x, it.second_ctrl_x, '0, 2, t);
      exp_item.left_c2_y  = blend(it.start_y, it.first_ctrl_y, it.second_ctrl_y, '0, 2, t);
      exp_item.split_x    = blend(it.start_x, it.first_ctrl_x, it.second_ctrl_x,
                                  it.end_x, 3, t);
      exp_item.split_y    = blend(it.start_y, it.first_ctrl_y, it.second_ctrl_y,
                                  it.end_y, 3, t);
      exp_item.right_c1_x = blend(it.first_ctrl_x, it.second_ctrl_x, it.end_x, '0, 2, t);
      exp_item.right_c1_y = blend(it.first_ctrl_y, it.second_ctrl_y, it.end_y, '0, 2, t);
      exp_item.right_c2_x = blend(it.second_ctrl_x, it.end_x, '0, '0, 1, t);
      exp_item.right_c2_y = blend(it.second_ctrl_y, it.end_y, '0, '0, 1, t);
      expected_q.push_back(exp_item);
      n_accepted++;
    endfunction

    function bit field_bad(string name, coord_t exp_v, coord_t got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(cbs_out_t got);
      cbs_out_t exp_item;
      bit       bad;
      if (expected_q.size() == 0) begin
        $display("%0t: result item with none outstanding, got %h", $time, got);
        n_errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      bad = 1'b0;
      bad |= field_bad("left_c1_x", exp_item.left_c1_x, got.left_c1_x);
      bad |= field_bad("left_c1_y", exp_item.left_c1_y, got.left_c1_y);
      bad |= field_bad("left_c2_x", exp_item.left_c2_x, got.left_c2_x);
      bad |= field_bad("left_c2_y", exp_item.left_c2_y, got.left_c2_y);
      bad |= field_bad("split_x", exp_item.split_x, got.split_x);
      bad |= field_bad("split_y", exp_item.split_y, got.split_y);
      bad |= field_bad("right_c1_x", exp_item.right_c1_x, got.right_c1_x);
      bad |= field_bad("right_c1_y", exp_item.right_c1_y, got.right_c1_y);
      bad |= field_bad("right_c2_x", exp_item.right_c2_x, got.right_c2_x);
      bad |= field_bad("right_c2_y", exp_item.right_c2_y, got.right_c2_y);
      if (bad) n_errors++;
      n_checked++;
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  cbs_in_t  in_item_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  cbs_out_t out_item_o;

  logic random_stall_en = 1'b0;
  logic hold_req = 1'b0;
  int   cycle_count = 0;

  split_scoreboard board = new();

  cubic_bezier_split_at_t_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, board.expected_q.size());
    $display("cubic_bezier_split_at_t_unit verification failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function coord_t rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom();
      5, 6:          return coord_t'($signed($urandom_range(0, 32)) - 16);
      7:             return 32'h7FFF_FFFF - $urandom_range(0, 3);
      8:             return 32'h8000_0000 + $urandom_range(0, 3);
      default:       return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
    endcase
  endfunction

  function tval_t rand_t();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return tval_t'($urandom_range(0, 65536));
    if (r < 80) return tval_t'($urandom_range(65537, 131071));
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return TOne;
      2:       return TOne >> 1;
      3:       return tval_t'(1);
      default: return TOne - 1;
    endcase
  endfunction

  function cbs_in_t make_item(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                              coord_t cx, coord_t cy, coord_t dx, coord_t dy,
                              tval_t t);
    cbs_in_t it;
    it.start_x = ax;
    it.start_y = ay;
    it.first_ctrl_x = bx;
    it.first_ctrl_y = by;
    it.second_ctrl_x = cx;
    it.second_ctrl_y = cy;
    it.end_x = dx;
    it.end_y = dy;
    it.split_t = t;
    return it;
  endfunction

  function cbs_in_t rand_item();
    coord_t pt;
    // A few degenerate curves where every point coincides.
    if ($urandom_range(0, 19) == 0) begin
      pt = rand_coord();
      return make_item(pt, pt, pt, pt, pt, pt, pt, pt, rand_t());
    end
    return make_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_t());
  endfunction

  // Holds the item on the input until the unit takes it.
  task automatic send_curve(input cbs_in_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(it);
  endtask

  task automatic sender_idle(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      in_item_i <= rand_item();
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int count, input bit with_gaps);
    int k;
    for (k = 0; k < count; k++) begin
      send_curve(rand_item());
      if (with_gaps) sender_idle(gap_len());
    end
  endtask

  task automatic run_directed();
    coord_t mx;
    coord_t mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_curve(make_item('0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_curve(make_item(mx, mx, mx, mx, mx, mx, mx, mx, TOne >> 1));
    send_curve(make_item(mn, mn, mn, mn, mn, mn, mn, mn, TOne >> 1));
    send_curve(make_item(mn, mx, mx, mn, mn, mx, mx, mn, TOne >> 1));
    send_curve(make_item(mn, mx, mx, mn, mn, mx, mx, mn, tval_t'(1)));
    send_curve(make_item(mn, mx, mx, mn, mn, mx, mx, mn, TOne - 1));
    send_curve(make_item(mx, mn, mn, mx, mx, mn, mn, mx, tval_t'(21845)));
    // The split parameter at its ends returns input points exactly.
    send_curve(make_item(mx, mn, 32'd17, -32'sd9, mn, mx, 32'd5, 32'd3, '0));
    send_curve(make_item(mx, mn, 32'd17, -32'sd9, mn, mx, 32'd5, 32'd3, TOne));
    // Values above one saturate, including the largest field value.
    send_curve(make_item(mx, mn, 32'd17, -32'sd9, mn, mx, 32'd5, 32'd3, TOne + 1));
    send_curve(make_item(mx, mn, 32'd17, -32'sd9, mn, mx, 32'd5, 32'd3, '1));
    // Exact halves in both signs check rounding away from zero.
    send_curve(make_item(-32'sd1, 32'd1, '0, '0, -32'sd1, 32'd1, '0, '0, TOne >> 1));
    send_curve(make_item(32'd1, -32'sd1, '0, '0, 32'd3, -32'sd3, '0, '0, TOne >> 1));
    send_curve(make_item(-32'sd3, 32'd3, 32'd0, 32'd0, 32'd0, 32'd0, -32'sd1, 32'd1,
                         TOne >> 1));
    send_curve(make_item(-32'sd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                         TOne >> 2));
    send_curve(make_item(32'd1, -32'sd1, -32'sd2, 32'd2, 32'd4, -32'sd4, 32'd7, -32'sd7,
                         tval_t'(3)));
    send_curve(make_item(mx, mx, mn, mn, mx, mx, mn, mn, tval_t'(43690)));
    send_curve(make_item(mn, '0, mn, '0, mn, '0, mn, '0, tval_t'(12345)));
    send_curve(make_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         tval_t'(16'hAAAA)));
    send_curve(make_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         tval_t'(16'h5555)));
  endtask

  // Result side: checks every accepted result item and decides the next stall.
  initial begin : result_side
    int stall_left;
    int hold_left;
    int r;
    bit hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) board.check_result(out_item_o);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!random_stall_en) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        r = $urandom_range(0, 99);
        if (r < 20) stall_left = $urandom_range(1, 3);
        else if (r < 26) stall_left = $urandom_range(4, 12);
        else if (r < 28) stall_left = $urandom_range(20, 60);
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    random_stall_en <= 1'b1;
    run_directed();

    // Full rate on both sides.
    random_stall_en <= 1'b0;
    send_random(300, 1'b0);
    wait_drained();

    random_stall_en <= 1'b1;
    send_random(500, 1'b1);

    // Long output hold while the input keeps offering items back to back.
    hold_req <= 1'b1;
    send_random(60, 1'b0);

    send_random(250, 1'b1);
    wait_drained();
    send_random(240, 1'b1);

    wait_drained();
    repeat (NumStages + 10) @(posedge clk_i);
    $display("%0d curves split, %0d result items checked, %0d mismatching items",
             board.n_accepted, board.n_checked, board.n_errors);
    $display("coverage: t at zero, one, above one and interior, extreme and small points");
    if (board.n_errors == 0 && board.expected_q.size() == 0) begin
      $display("cubic_bezier_split_at_t_unit verification clean");
    end else begin
      $display("cubic_bezier_split_at_t_unit verification failed");
    end
    $finish;
  end

endmodule
